@@ sv/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants for the box-projection UV block
// Beat payload structs, fixed-point constants, register indexes and the
// widths of the shared divider.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_V = 3'd6;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // shared divider: numerator < denominator * 2^DIV_Q_W
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_Q_W   = 17;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [31:0]        vertex_number;
    logic               last_of_triangle;
  } out_t;

endpackage

@@ sv/tbp_div.sv @@
// ----------------------------------------------------------------------------
// tbp_div: iterative restoring divider
// One quotient bit per cycle; the caller guarantees num < den * 2^DIV_Q_W.
// ----------------------------------------------------------------------------
module tbp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tbp_pkg::DIV_NUM_W-1:0]  num,
  input  logic [tbp_pkg::DIV_DEN_W-1:0]  den,
  output logic                           done,
  output logic [tbp_pkg::DIV_Q_W-1:0]    quot
);
  import tbp_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] dsh_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        dsh_r  <= DIV_NUM_W'({den, {(DIV_Q_W-1){1'b0}}});
        cnt_r  <= DIV_CNT_W'(DIV_Q_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // subtract where it fits, shift the divisor down one place
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= {q_r[DIV_Q_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("divider done without work");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy with zero count");
`endif

endmodule

@@ sv/triangle_box_projection_uv.sv @@
// ----------------------------------------------------------------------------
// triangle_box_projection_uv: box-projection UV mapping of one triangle
// Face normal, dominant axis and box-projected UVs for three vertices.
// ----------------------------------------------------------------------------
// A triangle beat (three Q16.16 corners) is taken only while the block is
// idle, and produces three vertex beats in the order a, b, c. The work runs
// through one sequencer: six cross-product multiplies and three squares on a
// single 33x33 multiplier, one right shift a cycle until the cross product
// fits in 30 bits (0 to 36 shifts), a 32-step bit-serial square root, then
// the shared 17-step divider for the three normal components and for up to
// two UV divisions per vertex. A UV coordinate that clamps to 0 or one skips
// its division. The next triangle is taken only after the last vertex beat
// has left and the block is back in idle; a stall on the result side delays
// that. Configuration writes belong to idle time. A degenerate triangle
// gets the normal (0, 1, 0).
// ----------------------------------------------------------------------------
module triangle_box_projection_uv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tbp_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tbp_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tbp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CONV, S_SHIFT, S_SQ, S_SQRT, S_NDIV, S_AXIS, S_PROJ, S_WAIT
  } state_t;

  // configuration
  logic signed [31:0] min_r [3];
  logic signed [31:0] max_r [3];
  logic               flip_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= 32'sd65536;
      end
      flip_v_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_X:  min_r[0] <= cfg_wdata;
        CFG_MIN_Y:  min_r[1] <= cfg_wdata;
        CFG_MIN_Z:  min_r[2] <= cfg_wdata;
        CFG_MAX_X:  max_r[0] <= cfg_wdata;
        CFG_MAX_Y:  max_r[1] <= cfg_wdata;
        CFG_MAX_Z:  max_r[2] <= cfg_wdata;
        CFG_FLIP_V: flip_v_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  state_t             state_r;
  in_t                tri_r;
  logic [2:0]         cnt_r;
  logic signed [66:0] cross_r [3];
  logic [65:0]        mag_r [3];
  logic [2:0]         neg_r;
  logic signed [65:0] prod_r;
  logic [61:0]        sum_r;
  logic [62:0]        x_r, res_r, bit_r;
  logic [31:0]        len_r;
  logic signed [15:0] norm_r [3];
  logic [1:0]         axis_r;
  logic [1:0]         k_r;
  logic               sel_r;
  logic [16:0]        u_r;
  logic               wait_r;
  logic               out_valid_r;
  out_t               out_r;
  logic [31:0]        vcnt_r;
  logic               div_start_r;
  logic [DIV_NUM_W-1:0] div_num_r;
  logic [DIV_DEN_W-1:0] div_den_r;
  logic               div_done;
  logic [DIV_Q_W-1:0] div_q;

  tbp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // edges and the shared multiplier
  logic signed [32:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [2:0]         pm;

  assign e1x = 33'(tri_r.b_x) - 33'(tri_r.a_x);
  assign e1y = 33'(tri_r.b_y) - 33'(tri_r.a_y);
  assign e1z = 33'(tri_r.b_z) - 33'(tri_r.a_z);
  assign e2x = 33'(tri_r.c_x) - 33'(tri_r.a_x);
  assign e2y = 33'(tri_r.c_y) - 33'(tri_r.a_y);
  assign e2z = 33'(tri_r.c_z) - 33'(tri_r.a_z);
  assign pm  = cnt_r - 3'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      mul_a = $signed({3'b000, mag_r[cnt_r[1:0]][29:0]});
      mul_b = mul_a;
    end else begin
      unique case (cnt_r)
        3'd0:    begin mul_a = e1y; mul_b = e2z; end
        3'd1:    begin mul_a = e1z; mul_b = e2y; end
        3'd2:    begin mul_a = e1z; mul_b = e2x; end
        3'd3:    begin mul_a = e1x; mul_b = e2z; end
        3'd4:    begin mul_a = e1x; mul_b = e2y; end
        3'd5:    begin mul_a = e1y; mul_b = e2x; end
        default: begin mul_a = '0;  mul_b = '0;  end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  // one step of the bit-serial square root
  logic [62:0] trial;
  logic        take;
  logic [62:0] res_nxt;

  assign trial   = res_r + bit_r;
  assign take    = x_r >= trial;
  assign res_nxt = take ? (res_r >> 1) + bit_r : res_r >> 1;

  // normal component from the divider, clamped to one
  logic [14:0]        nmag;
  logic signed [15:0] nval;

  assign nmag = (div_q > DIV_Q_W'(ONE_Q14)) ? ONE_Q14[14:0] : div_q[14:0];
  assign nval = neg_r[cnt_r[1:0]] ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});

  // magnitudes of the normal for the axis choice
  logic [15:0] anx, any, anz;
  assign anx = norm_r[0][15] ? 16'(-norm_r[0]) : 16'(norm_r[0]);
  assign any = norm_r[1][15] ? 16'(-norm_r[1]) : 16'(norm_r[1]);
  assign anz = norm_r[2][15] ? 16'(-norm_r[2]) : 16'(norm_r[2]);

  // projection of the current vertex on the current coordinate
  logic signed [31:0] cp [3];
  logic [1:0]         coord;
  logic signed [33:0] off;
  logic signed [32:0] size_raw;
  logic [31:0]        size;
  logic               off_le0, off_ge;
  logic               proj_fin;
  logic [16:0]        proj_t;
  logic [16:0]        u_m, v_m;

  always_comb begin
    unique case (k_r)
      2'd0:    begin cp[0] = tri_r.a_x; cp[1] = tri_r.a_y; cp[2] = tri_r.a_z; end
      2'd1:    begin cp[0] = tri_r.b_x; cp[1] = tri_r.b_y; cp[2] = tri_r.b_z; end
      default: begin cp[0] = tri_r.c_x; cp[1] = tri_r.c_y; cp[2] = tri_r.c_z; end
    endcase
    // x axis: u from z, v from y; y axis: u from x, v from z; z axis: u x, v y
    unique case (axis_r)
      2'd0:    coord = sel_r ? 2'd1 : 2'd2;
      2'd1:    coord = sel_r ? 2'd2 : 2'd0;
      default: coord = sel_r ? 2'd1 : 2'd0;
    endcase
  end

  assign off      = 34'(cp[coord]) - 34'(min_r[coord]);
  assign size_raw = 33'(max_r[coord]) - 33'(min_r[coord]);
  assign size     = (size_raw < 33'sd1) ? 32'd1 : size_raw[31:0];
  assign off_le0  = off[33] || (off == '0);
  assign off_ge   = off >= $signed({2'b00, size});
  assign proj_fin = wait_r ? div_done : (off_le0 || off_ge);
  assign proj_t   = wait_r ? div_q : (off_le0 ? 17'd0 : ONE_Q16);

  always_comb begin
    u_m = u_r;
    v_m = proj_t;
    unique case (axis_r)
      2'd0:    if (norm_r[0] > 16'sd0) u_m = ONE_Q16 - u_r;
      2'd1:    if (norm_r[1] < 16'sd0) v_m = ONE_Q16 - proj_t;
      default: if (norm_r[2] < 16'sd0) u_m = ONE_Q16 - u_r;
    endcase
    if (flip_v_r) v_m = ONE_Q16 - v_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wait_r      <= 1'b0;
      div_start_r <= 1'b0;
      vcnt_r      <= '0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            tri_r   <= in_data;
            cnt_r   <= '0;
            for (int i = 0; i < 3; i++) cross_r[i] <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // multiply one pair, fold the previous product into its component
          if (cnt_r < 3'd6) prod_r <= prod;
          if (cnt_r != 3'd0) begin
            if (pm[0]) cross_r[pm[2:1]] <= cross_r[pm[2:1]] - 67'(prod_r);
            else       cross_r[pm[2:1]] <= cross_r[pm[2:1]] + 67'(prod_r);
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd6) state_r <= S_CONV;
        end
        S_CONV: begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= cross_r[i][66] ? 66'(-cross_r[i]) : 66'(cross_r[i]);
            neg_r[i] <= cross_r[i][66];
          end
          if (cross_r[0] == '0 && cross_r[1] == '0 && cross_r[2] == '0) begin
            norm_r[0] <= '0;
            norm_r[1] <= ONE_Q14;
            norm_r[2] <= '0;
            state_r   <= S_AXIS;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if ((mag_r[0][65:30] | mag_r[1][65:30] | mag_r[2][65:30]) != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r < 3'd3) prod_r <= prod;
          if (cnt_r != 3'd0) sum_r <= sum_r + prod_r[61:0];
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            x_r     <= {1'b0, sum_r + prod_r[61:0]};
            res_r   <= '0;
            bit_r   <= 63'h4000_0000_0000_0000;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (take) x_r <= x_r - trial;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            len_r   <= res_nxt[31:0];
            cnt_r   <= '0;
            state_r <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (!wait_r) begin
            div_start_r <= 1'b1;
            div_num_r   <= DIV_NUM_W'({mag_r[cnt_r[1:0]][29:0], 14'd0})
                           + DIV_NUM_W'(len_r >> 1);
            div_den_r   <= DIV_DEN_W'(len_r);
            wait_r      <= 1'b1;
          end else if (div_done) begin
            wait_r               <= 1'b0;
            norm_r[cnt_r[1:0]]   <= nval;
            cnt_r                <= cnt_r + 3'd1;
            if (cnt_r == 3'd2) state_r <= S_AXIS;
          end
        end
        S_AXIS: begin
          // ties go to x, then y
          if (anx >= any && anx >= anz) axis_r <= 2'd0;
          else if (any >= anz)          axis_r <= 2'd1;
          else                          axis_r <= 2'd2;
          k_r     <= '0;
          sel_r   <= 1'b0;
          state_r <= S_PROJ;
        end
        S_PROJ: begin
          if (!wait_r && !proj_fin) begin
            div_start_r <= 1'b1;
            div_num_r   <= DIV_NUM_W'({off[31:0], 16'd0}) + DIV_NUM_W'(size >> 1);
            div_den_r   <= DIV_DEN_W'(size);
            wait_r      <= 1'b1;
          end else if (proj_fin) begin
            wait_r <= 1'b0;
            if (!sel_r) begin
              u_r   <= proj_t;
              sel_r <= 1'b1;
            end else begin
              out_r.pos_x            <= cp[0];
              out_r.pos_y            <= cp[1];
              out_r.pos_z            <= cp[2];
              out_r.tex_u            <= u_m;
              out_r.tex_v            <= v_m;
              out_r.norm_x           <= norm_r[0];
              out_r.norm_y           <= norm_r[1];
              out_r.norm_z           <= norm_r[2];
              out_r.vertex_number    <= vcnt_r;
              out_r.last_of_triangle <= (k_r == 2'd2);
              out_valid_r            <= 1'b1;
              state_r                <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          // hold the beat until the consumer takes it
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            vcnt_r      <= vcnt_r + 32'd1;
            if (k_r == 2'd2) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 2'd1;
              sel_r   <= 1'b0;
              state_r <= S_PROJ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_WAIT) else $error("result beat outside wait state");
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.tex_u <= ONE_Q16 && out_r.tex_v <= ONE_Q16))
    else $error("uv out of range");
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> wait_r) else $error("unexpected divider result");
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && out_r.last_of_triangle) |=> state_r == S_IDLE)
    else $error("triangle did not end after its last vertex");
`endif

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: regression for triangle_box_projection_uv
// Drives triangles with random idling and back-pressure, predicts the three
// vertex beats of each one (normal, dominant axis, box-projected UV, counter)
// and compares every output beat with them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tbp_pkg::*;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  in_t            in_data;
  logic           out_valid;
  logic           out_stall;
  out_t           out_data;
  logic           cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  triangle_box_projection_uv u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's registers and vertex counter.
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic               mirror_v;
  logic [31:0]        vtx_count;

  out_t vertex_queue [$];
  int   mismatches;
  bit   quiet_tail;      // no idling in the last part of the run
  int   hold_cycles;     // long receiver hold-off, counted in its own process

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [16:0] box_coord(logic signed [31:0] p,
                                            logic signed [31:0] lo,
                                            logic signed [31:0] hi);
    longint off;
    longint span;
    off  = longint'(p) - longint'(lo);
    span = longint'(hi) - longint'(lo);
    if (span < 1) span = 1;
    if (off <= 0) return 17'd0;
    if (off >= span) return ONE_Q16;
    return 17'((off * 65536 + span / 2) / span);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Build the three expected vertex beats of one triangle.
  task automatic predict_vertices(input in_t tri_in);
    logic signed [31:0] pt [3][3];
    logic signed [33:0] e1 [3];
    logic signed [33:0] e2 [3];
    logic signed [69:0] cr [3];
    logic [69:0]        cmag [3];
    logic [69:0]        maxmag;
    longint unsigned    r [3];
    longint unsigned    sumsq;
    longint unsigned    len;
    longint unsigned    m;
    logic signed [15:0] nrm [3];
    int                 blen;
    int                 sh;
    int                 axis;
    int                 abs_n [3];
    logic [16:0]        u;
    logic [16:0]        v;
    out_t               beat;
    pt[0] = '{tri_in.a_x, tri_in.a_y, tri_in.a_z};
    pt[1] = '{tri_in.b_x, tri_in.b_y, tri_in.b_z};
    pt[2] = '{tri_in.c_x, tri_in.c_y, tri_in.c_z};
    for (int i = 0; i < 3; i++) begin
      e1[i] = 34'(pt[1][i]) - 34'(pt[0][i]);
      e2[i] = 34'(pt[2][i]) - 34'(pt[0][i]);
    end
    cr[0] = 70'(e1[1]) * 70'(e2[2]) - 70'(e1[2]) * 70'(e2[1]);
    cr[1] = 70'(e1[2]) * 70'(e2[0]) - 70'(e1[0]) * 70'(e2[2]);
    cr[2] = 70'(e1[0]) * 70'(e2[1]) - 70'(e1[1]) * 70'(e2[0]);
    maxmag = '0;
    for (int i = 0; i < 3; i++) begin
      cmag[i] = cr[i] < 0 ? 70'(-cr[i]) : 70'(cr[i]);
      if (cmag[i] > maxmag) maxmag = cmag[i];
    end
    if (maxmag == 0) begin
      nrm = '{16'sd0, 16'sd16384, 16'sd0};
    end else begin
      blen = 0;
      for (int b = 0; b < 70; b++) if (maxmag[b]) blen = b + 1;
      sh = blen > 30 ? blen - 30 : 0;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        r[i] = 64'(cmag[i] >> sh);
        sumsq += r[i] * r[i];
      end
      len = isqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        m = (r[i] * 16384 + len / 2) / len;
        if (m > 16384) m = 16384;
        nrm[i] = cr[i] < 0 ? -16'(m) : 16'(m);
      end
    end
    for (int i = 0; i < 3; i++) abs_n[i] = nrm[i] < 0 ? -int'(nrm[i]) : int'(nrm[i]);
    if (abs_n[0] >= abs_n[1] && abs_n[0] >= abs_n[2]) axis = 0;
    else if (abs_n[1] >= abs_n[2]) axis = 1;
    else axis = 2;
    for (int k = 0; k < 3; k++) begin
      case (axis)
        0: begin
          u = box_coord(pt[k][2], box_lo[2], box_hi[2]);
          v = box_coord(pt[k][1], box_lo[1], box_hi[1]);
          if (nrm[0] > 0) u = ONE_Q16 - u;
        end
        1: begin
          u = box_coord(pt[k][0], box_lo[0], box_hi[0]);
          v = box_coord(pt[k][2], box_lo[2], box_hi[2]);
          if (nrm[1] < 0) v = ONE_Q16 - v;
        end
        default: begin
          u = box_coord(pt[k][0], box_lo[0], box_hi[0]);
          v = box_coord(pt[k][1], box_lo[1], box_hi[1]);
          if (nrm[2] < 0) u = ONE_Q16 - u;
        end
      endcase
      if (mirror_v) v = ONE_Q16 - v;
      beat.pos_x = pt[k][0];
      beat.pos_y = pt[k][1];
      beat.pos_z = pt[k][2];
      beat.tex_u = u;
      beat.tex_v = v;
      beat.norm_x = nrm[0];
      beat.norm_y = nrm[1];
      beat.norm_z = nrm[2];
      beat.vertex_number = vtx_count;
      beat.last_of_triangle = (k == 2);
      vtx_count++;
      vertex_queue = {vertex_queue, beat};
    end
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected vertex beat %p", out_data);
      end else begin
        want = vertex_queue.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: vertex mismatch\n  expected %p\n  actual   %p", want, out_data);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MIN_X:  box_lo[0] = val;
      CFG_MIN_Y:  box_lo[1] = val;
      CFG_MIN_Z:  box_lo[2] = val;
      CFG_MAX_X:  box_hi[0] = val;
      CFG_MAX_Y:  box_hi[1] = val;
      CFG_MAX_Z:  box_hi[2] = val;
      CFG_FLIP_V: mirror_v  = val[0];
      default: ;
    endcase
    // the enable drops low between writes, so each write is a separate pulse
    @(posedge clk);
  endtask

  // Offer one triangle; the beat is accepted at an edge with valid high and stall low.
  task automatic send_triangle(input in_t tri_in, input bit allow_gap);
    if (allow_gap && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tri_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertices(tri_in);
  endtask

  // Wait until every expected vertex has been seen, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 196608)) - 32'd65536;
    endcase
  endfunction

  function automatic in_t rand_triangle();
    in_t t;
    t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // make some triangles collinear or repeated corners
    if ($urandom_range(0, 15) == 0) begin
      t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
    end
    return t;
  endfunction

  // Directed triangles; a checked row also carries the first vertex's UV
  // and normal as worked out by hand at reset settings.
  typedef struct {
    in_t         tri_in;
    bit          check;
    logic [16:0] u0;
    logic [16:0] v0;
    logic [15:0] nx, ny, nz;
  } row_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NMIN = 32'h8000_0000;

  row_t directed [] = '{
    // degenerate: all corners at the origin, normal (0,1,0), y axis
    '{'{0,0,0, 0,0,0, 0,0,0}, 1, 17'd0, 17'd0, 16'd0, 16'd16384, 16'd0},
    // flat in z = 0, counter-clockwise: normal +z, no mirror
    '{'{0,0,0, ONE,0,0, 0,ONE,0}, 1, 17'd0, 17'd0, 16'd0, 16'd0, 16'd16384},
    // clockwise: normal -z, u mirrored
    '{'{0,0,0, 0,ONE,0, ONE,0,0}, 1, 17'd65536, 17'd0, 16'd0, 16'd0, -16'sd16384},
    // plane x = half: normal +x, u mirrored from z
    '{'{HALF,HALF,HALF, HALF,ONE,HALF, HALF,HALF,ONE}, 1,
      17'd32768, 17'd32768, 16'd16384, 16'd0, 16'd0},
    // plane y: normal -y, v mirrored
    '{'{0,HALF,0, ONE,HALF,0, 0,HALF,ONE}, 1, 17'd0, 17'd65536,
      16'd0, -16'sd16384, 16'd0},
    // outside the box both ways
    '{'{NMIN,NMIN,NMIN, PMAX,NMIN,NMIN, NMIN,PMAX,NMIN}, 0, 0, 0, 0, 0, 0},
    '{'{PMAX,PMAX,PMAX, NMIN,PMAX,PMAX, PMAX,NMIN,PMAX}, 0, 0, 0, 0, 0, 0},
    // largest cross product magnitudes
    '{'{NMIN,NMIN,NMIN, PMAX,PMAX,NMIN, PMAX,NMIN,PMAX}, 0, 0, 0, 0, 0, 0},
    '{'{PMAX,NMIN,PMAX, NMIN,PMAX,PMAX, NMIN,NMIN,NMIN}, 0, 0, 0, 0, 0, 0},
    // tie |nx| = |ny| = |nz|: x wins
    '{'{ONE,0,0, 0,ONE,0, 0,0,ONE}, 0, 0, 0, 0, 0, 0},
    // tie |ny| = |nz|: y wins
    '{'{0,0,0, ONE,0,0, 0,ONE,ONE}, 0, 0, 0, 0, 0, 0},
    // collinear, tiny edges
    '{'{1,1,1, 2,2,2, 3,3,3}, 0, 0, 0, 0, 0, 0},
    '{'{0,0,0, 1,0,0, 0,1,0}, 0, 0, 0, 0, 0, 0},
    '{'{HALF,32'h4000,32'hC000, 32'h1234,32'hFFFF_F000,ONE, 7,ONE,32'h2_0000},
      0, 0, 0, 0, 0, 0}
  };

  task automatic run_random(input int count, input bit allow_gap);
    for (int n = 0; n < count; n++) send_triangle(rand_triangle(), allow_gap);
  endtask

  initial begin
    out_t first;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_MIN_X;
    cfg_wdata  = '0;
    mismatches = 0;
    quiet_tail = 1'b0;
    hold_cycles = 0;
    box_lo     = '{32'sd0, 32'sd0, 32'sd0};
    box_hi     = '{32'sd65536, 32'sd65536, 32'sd65536};
    mirror_v   = 1'b0;
    vtx_count  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings; spot-check first vertex where typed in.
    foreach (directed[i]) begin
      send_triangle(directed[i].tri_in, 1'b0);
      if (directed[i].check) begin
        first = vertex_queue[vertex_queue.size() - 3];
        if (first.tex_u !== directed[i].u0 || first.tex_v !== directed[i].v0 ||
            first.norm_x !== directed[i].nx || first.norm_y !== directed[i].ny ||
            first.norm_z !== directed[i].nz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: directed row %0d predicted %p", i, first);
        end
      end
    end

    // Long receiver hold-off while triangles keep coming: the block backs up.
    hold_cycles = 600;
    run_random(6, 1'b0);
    drain();

    // Wide box, flip on.
    write_reg(CFG_MIN_X, 32'hFFFE_0000);
    write_reg(CFG_MIN_Y, 32'hFFFF_0000);
    write_reg(CFG_MIN_Z, 32'hFFFF_8000);
    write_reg(CFG_MAX_X, 32'h0002_0000);
    write_reg(CFG_MAX_Y, 32'h0001_8000);
    write_reg(CFG_MAX_Z, 32'h0003_0000);
    write_reg(CFG_FLIP_V, 32'h1);
    run_random(60, 1'b1);
    drain();

    // Extreme box: full signed range.
    write_reg(CFG_MIN_X, NMIN);
    write_reg(CFG_MIN_Y, NMIN);
    write_reg(CFG_MIN_Z, NMIN);
    write_reg(CFG_MAX_X, PMAX);
    write_reg(CFG_MAX_Y, PMAX);
    write_reg(CFG_MAX_Z, PMAX);
    write_reg(CFG_FLIP_V, 32'h0);
    run_random(50, 1'b1);
    drain();

    // Inverted and zero-size boxes: coordinates collapse to 0 or one.
    write_reg(CFG_MIN_X, PMAX);
    write_reg(CFG_MAX_X, NMIN);
    write_reg(CFG_MIN_Y, HALF);
    write_reg(CFG_MAX_Y, HALF);
    write_reg(CFG_MIN_Z, 32'h0);
    write_reg(CFG_MAX_Z, 32'h1);
    write_reg(CFG_FLIP_V, 32'h1);
    run_random(40, 1'b1);
    drain();

    // Random box, then a quiet tail with no idling on either side.
    for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], rand_coord());
    write_reg(CFG_FLIP_V, 32'($urandom_range(0, 1)));
    run_random(40, 1'b1);
    quiet_tail = 1'b1;
    run_random(20, 1'b0);
    drain();

    if (mismatches == 0 && vertex_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
